[rtl/lob_pkg.sv]
// Shared definitions for the order book matcher.
// Holds the cell operation codes used by the book side and its cells.
`timescale 1ns / 1ps

package lob_pkg;

    // Operation applied to every cell of one book side in a cycle.
    typedef enum logic [5:0] {
        OP_HOLD    = 6'b000001,
        OP_CLEAR   = 6'b000010,
        OP_LOAD    = 6'b000100,
        OP_INSERT  = 6'b001000,
        OP_REPLACE = 6'b010000,
        OP_POP     = 6'b100000
    } lob_op_t;

endpackage

[rtl/lob_cell.sv]
// One slot of a sorted book side; talks only to its two neighbors.
// Depends on lob_pkg for the operation codes.
`timescale 1ns / 1ps

module lob_cell
    import lob_pkg::*;
#(
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 16,
    parameter bit IS_BID     = 1'b0,
    parameter bit IS_HEAD    = 1'b0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lob_op_t               op,
    input  logic [PRICE_BITS-1:0] v_price,
    input  logic [QTY_BITS-1:0]   v_qty,
    input  logic                  prev_valid,
    input  logic [PRICE_BITS-1:0] prev_price,
    input  logic [QTY_BITS-1:0]   prev_qty,
    input  logic                  next_valid,
    input  logic [PRICE_BITS-1:0] next_price,
    input  logic [QTY_BITS-1:0]   next_qty,
    output logic                  valid,
    output logic [PRICE_BITS-1:0] price,
    output logic [QTY_BITS-1:0]   qty
);

    logic                  valid_reg, valid_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_BITS-1:0]   qty_reg, qty_next;

    // True when the word (ap, aq) sorts strictly ahead of (bp, bq).
    function automatic logic better(input logic [PRICE_BITS-1:0] ap,
                                    input logic [QTY_BITS-1:0] aq,
                                    input logic [PRICE_BITS-1:0] bp,
                                    input logic [QTY_BITS-1:0] bq);
        if (IS_BID)
            return (ap > bp) || ((ap == bp) && (aq > bq));
        else
            return (ap < bp) || ((ap == bp) && (aq < bq));
    endfunction

    logic v_above_prev, v_above_self, v_above_next;

    // An empty slot sorts behind everything.
    assign v_above_prev = !IS_HEAD && (!prev_valid || better(v_price, v_qty, prev_price, prev_qty));
    assign v_above_self = !valid_reg || better(v_price, v_qty, price_reg, qty_reg);
    assign v_above_next = !next_valid || better(v_price, v_qty, next_price, next_qty);

    always_comb
    begin
        valid_next = valid_reg;
        price_next = price_reg;
        qty_next   = qty_reg;
        case (op)
            OP_HOLD:
            begin
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            OP_LOAD:
            begin
                valid_next = IS_HEAD;
                price_next = v_price;
                qty_next   = v_qty;
            end
            OP_INSERT:
            begin
                if (v_above_prev)
                begin
                    valid_next = prev_valid;
                    price_next = prev_price;
                    qty_next   = prev_qty;
                end
                else if (v_above_self)
                begin
                    valid_next = 1'b1;
                    price_next = v_price;
                    qty_next   = v_qty;
                end
            end
            OP_REPLACE:
            begin
                // The head leaves and the new word is sorted into the rest.
                if (!IS_HEAD && v_above_self)
                begin
                end
                else if (v_above_next)
                begin
                    valid_next = 1'b1;
                    price_next = v_price;
                    qty_next   = v_qty;
                end
                else
                begin
                    valid_next = next_valid;
                    price_next = next_price;
                    qty_next   = next_qty;
                end
            end
            OP_POP:
            begin
                valid_next = next_valid;
                price_next = next_price;
                qty_next   = next_qty;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

    assign valid = valid_reg;
    assign price = price_reg;
    assign qty   = qty_reg;

endmodule

[rtl/lob_side.sv]
// One side of the book: a row of sorted cells, best word in the first cell.
// Depends on lob_pkg and lob_cell.
`timescale 1ns / 1ps

module lob_side
    import lob_pkg::*;
#(
    parameter int BOOK_DEPTH = 64,
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 16,
    parameter bit IS_BID     = 1'b0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lob_op_t               op,
    input  logic [PRICE_BITS-1:0] v_price,
    input  logic [QTY_BITS-1:0]   v_qty,
    output logic                  head_valid,
    output logic [PRICE_BITS-1:0] head_price,
    output logic [QTY_BITS-1:0]   head_qty
);

    logic                  c_valid [BOOK_DEPTH+1];
    logic [PRICE_BITS-1:0] c_price [BOOK_DEPTH+1];
    logic [QTY_BITS-1:0]   c_qty   [BOOK_DEPTH+1];

    // An always empty slot past the tail feeds the last cell.
    assign c_valid[BOOK_DEPTH] = 1'b0;
    assign c_price[BOOK_DEPTH] = '0;
    assign c_qty[BOOK_DEPTH]   = '0;

    for (genvar i = 0; i < BOOK_DEPTH; i++)
    begin : g_cell
        lob_cell #(
            .PRICE_BITS(PRICE_BITS),
            .QTY_BITS  (QTY_BITS),
            .IS_BID    (IS_BID),
            .IS_HEAD   (i == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .v_price   (v_price),
            .v_qty     (v_qty),
            .prev_valid(c_valid[(i == 0) ? 0 : i-1]),
            .prev_price(c_price[(i == 0) ? 0 : i-1]),
            .prev_qty  (c_qty[(i == 0) ? 0 : i-1]),
            .next_valid(c_valid[i+1]),
            .next_price(c_price[i+1]),
            .next_qty  (c_qty[i+1]),
            .valid     (c_valid[i]),
            .price     (c_price[i]),
            .qty       (c_qty[i])
        );
    end

    assign head_valid = c_valid[0];
    assign head_price = c_price[0];
    assign head_qty   = c_qty[0];

endmodule

[rtl/limit_order_book_matcher.sv]
// Top level of the limit order book matcher: control sequencer and result register.
// Depends on lob_pkg and lob_side (which builds on lob_cell).
`timescale 1ns / 1ps

//  Channel  Handshake            Words carried
//  input    in_valid, in_stall   action, quantity, limit_price, new_session
//  output   out_valid, out_stall ask_present, best_ask, bid_present, best_bid,
//                                trade_seen, last_trade_price, book_overflow
//
// After acceptance an order is worked in steps: one step to insert, one step
// per match (the two cells at the head of the sides trade), one step to see
// that the sides no longer cross, and one to load the result register. The
// sequencer is idle again only after that last step, so a new order is taken
// only once the result of the last one has been loaded.
// Reset empties both sides at once, since every cell has its own valid bit.
// A new word is taken only while the sequencer is idle; the sequencer waits
// with a finished order while the result register is full and stalled, and
// the result register holds under out_stall while the next order is already
// being worked.

module limit_order_book_matcher
    import lob_pkg::*;
#(
    parameter int BOOK_DEPTH = 64,
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [QTY_BITS-1:0]   quantity,
    input  logic [PRICE_BITS-1:0] limit_price,
    input  logic                  new_session,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  ask_present,
    output logic [PRICE_BITS-1:0] best_ask,
    output logic                  bid_present,
    output logic [PRICE_BITS-1:0] best_bid,
    output logic                  trade_seen,
    output logic [PRICE_BITS-1:0] last_trade_price,
    output logic                  book_overflow
);

    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(BOOK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_INS   = 4'b0010,
        S_MATCH = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // The accepted order, held while it is worked.
    logic                  side_reg;
    logic [QTY_BITS-1:0]   qty_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic                  sess_reg;

    logic [CW-1:0]         ask_cnt_reg, ask_cnt_next;
    logic [CW-1:0]         bid_cnt_reg, bid_cnt_next;
    logic [PRICE_BITS-1:0] last_reg, last_next;
    logic                  trade_reg, trade_next;
    logic                  ovf_reg, ovf_next;

    logic                  out_valid_reg;
    logic                  o_ask_p_reg, o_bid_p_reg, o_trade_reg, o_ovf_reg;
    logic [PRICE_BITS-1:0] o_ask_reg, o_bid_reg, o_last_reg;

    lob_op_t               ask_op, bid_op;
    logic [PRICE_BITS-1:0] ask_vp, bid_vp;
    logic [QTY_BITS-1:0]   ask_vq, bid_vq;
    logic                  ask_hv, bid_hv;
    logic [PRICE_BITS-1:0] ask_hp, bid_hp;
    logic [QTY_BITS-1:0]   ask_hq, bid_hq;

    logic                  book_cross;
    logic [QTY_BITS-1:0]   common, ask_rem, bid_rem;
    logic                  out_free;

    lob_side #(
        .BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS), .IS_BID(1'b0)
    ) u_ask (
        .clk(clk), .rst_n(rst_n), .op(ask_op), .v_price(ask_vp), .v_qty(ask_vq),
        .head_valid(ask_hv), .head_price(ask_hp), .head_qty(ask_hq)
    );

    lob_side #(
        .BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS), .IS_BID(1'b1)
    ) u_bid (
        .clk(clk), .rst_n(rst_n), .op(bid_op), .v_price(bid_vp), .v_qty(bid_vq),
        .head_valid(bid_hv), .head_price(bid_hp), .head_qty(bid_hq)
    );

    // The two heads trade while the best ask is at or below the best bid.
    assign book_cross = ask_hv && bid_hv && (ask_hp <= bid_hp);
    assign common     = (ask_hq < bid_hq) ? ask_hq : bid_hq;
    assign ask_rem    = ask_hq - common;
    assign bid_rem    = bid_hq - common;

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        ask_op       = OP_HOLD;
        bid_op       = OP_HOLD;
        ask_vp       = price_reg;
        ask_vq       = qty_reg;
        bid_vp       = price_reg;
        bid_vq       = qty_reg;
        ask_cnt_next = ask_cnt_reg;
        bid_cnt_next = bid_cnt_reg;
        last_next    = last_reg;
        trade_next   = trade_reg;
        ovf_next     = ovf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_INS;
            end
            S_INS:
            begin
                ovf_next   = 1'b0;
                state_next = S_MATCH;
                if (sess_reg)
                begin
                    // A new session empties both sides; the order lands alone.
                    last_next  = '0;
                    trade_next = 1'b0;
                    ask_op     = side_reg ? OP_CLEAR : OP_LOAD;
                    bid_op     = side_reg ? OP_LOAD : OP_CLEAR;
                    ask_cnt_next = side_reg ? CW'(0) : CW'(1);
                    bid_cnt_next = side_reg ? CW'(1) : CW'(0);
                end
                else if (!side_reg)
                begin
                    if (ask_cnt_reg == FULL)
                        ovf_next = 1'b1;
                    else
                    begin
                        ask_op       = OP_INSERT;
                        ask_cnt_next = ask_cnt_reg + CW'(1);
                    end
                end
                else
                begin
                    if (bid_cnt_reg == FULL)
                        ovf_next = 1'b1;
                    else
                    begin
                        bid_op       = OP_INSERT;
                        bid_cnt_next = bid_cnt_reg + CW'(1);
                    end
                end
            end
            S_MATCH:
            begin
                ask_vp = ask_hp;
                ask_vq = ask_rem;
                bid_vp = bid_hp;
                bid_vq = bid_rem;
                if (book_cross)
                begin
                    last_next  = ask_hp;
                    trade_next = 1'b1;
                    // A filled order leaves; a partial fill is sorted back in.
                    if (ask_rem == '0)
                    begin
                        ask_op       = OP_POP;
                        ask_cnt_next = ask_cnt_reg - CW'(1);
                    end
                    else
                        ask_op = OP_REPLACE;
                    if (bid_rem == '0)
                    begin
                        bid_op       = OP_POP;
                        bid_cnt_next = bid_cnt_reg - CW'(1);
                    end
                    else
                        bid_op = OP_REPLACE;
                end
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ask_cnt_reg   <= '0;
            bid_cnt_reg   <= '0;
            last_reg      <= '0;
            trade_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ask_cnt_reg <= ask_cnt_next;
            bid_cnt_reg <= bid_cnt_next;
            last_reg    <= last_next;
            trade_reg   <= trade_next;
            ovf_reg     <= ovf_next;
            if (state_reg == S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            side_reg  <= action;
            qty_reg   <= quantity;
            price_reg <= limit_price;
            sess_reg  <= new_session;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            o_ask_p_reg <= ask_hv;
            o_ask_reg   <= ask_hv ? ask_hp : '0;
            o_bid_p_reg <= bid_hv;
            o_bid_reg   <= bid_hv ? bid_hp : '0;
            o_trade_reg <= trade_reg;
            o_last_reg  <= trade_reg ? last_reg : '0;
            o_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign ask_present      = o_ask_p_reg;
    assign best_ask         = o_ask_reg;
    assign bid_present      = o_bid_p_reg;
    assign best_bid         = o_bid_reg;
    assign trade_seen       = o_trade_reg;
    assign last_trade_price = o_last_reg;
    assign book_overflow    = o_ovf_reg;

endmodule
